// ----- design/dvc_pkg.sv -----
// ============================================================================
// Docking velocity controller package
// Register indexes and fixed-point constants shared by the controller.
// ============================================================================
package dvc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TARGET_DISTANCE = 3'd0;
    localparam logic [2:0] CFG_SIDE_THRESHOLD  = 3'd1;
    localparam logic [2:0] CFG_LEFT_OFFSET     = 3'd2;
    localparam logic [2:0] CFG_FAST_Y_SPEED    = 3'd3;
    localparam logic [2:0] CFG_SLOW_Y_SPEED    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] TARGET_DISTANCE_RST = 16'd20000;
    localparam logic [15:0] SIDE_THRESHOLD_RST  = 16'd10000;
    localparam logic [15:0] LEFT_OFFSET_RST     = 16'd800;
    localparam logic [14:0] FAST_Y_SPEED_RST    = 15'd8192;
    localparam logic [14:0] SLOW_Y_SPEED_RST    = 15'd1638;

    // Q1.14 unity, the largest speed magnitude
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // Yaw rate limit of 1.27 in Q1.14
    localparam logic [16:0] ANG_LIMIT = 17'd20808;

    // Smallest difference magnitude whose yaw rate is already beyond the limit
    localparam logic [13:0] ANG_MAG_CAP = 14'd8324;

    // Smallest error magnitude whose forward speed is already beyond unity
    localparam logic [10:0] FWD_MAG_CAP = 11'd2001;

    // ceil(2^32 / 10): floor division by ten for numerators below 2^30
    localparam logic [28:0] DIV10_RECIP = 29'd429496730;
    localparam int unsigned DIV10_SHIFT = 32;

    // ceil(2^28 / 125): floor division by 125 for numerators below 2^21
    localparam logic [21:0] DIV125_RECIP = 22'd2147484;
    localparam int unsigned DIV125_SHIFT = 28;

endpackage

// ----- design/docking_velocity_controller_top.sv -----
// ============================================================================
// Docking velocity controller
// Filters two rear range readings and turns them, with the side sensors,
// into yaw rate, forward speed and sideways speed commands in Q1.14.
// ============================================================================
//
//  Channel  Direction  Handshake             Contents
//  s_       in         s_valid / s_ready     side select, rear and side readings
//  m_       out        m_valid / m_ready     angular rate, forward, sideways, docked
//  cfg_     in         cfg_valid / cfg_ready register index and write data
//
//  Each transaction runs through four register stages, and one transaction
//  is taken every cycle while the output is not stalled. The rear filter
//  state advances as a sample leaves the input stage.
//  Every stage holds its contents while the stage after it is full and
//  stalled; an empty stage still takes data, so bubbles close up.
//  Reset clears the configuration to its defaults and the filters to zero.

module docking_velocity_controller_top
    import dvc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_is_left,
    input  logic [15:0]        s_behind_left_raw,
    input  logic [15:0]        s_behind_right_raw,
    input  logic [15:0]        s_side_left_slow,
    input  logic [15:0]        s_side_left_stop,
    input  logic [15:0]        s_side_right_slow,
    input  logic [15:0]        s_side_right_stop,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_angular_rate,
    output logic signed [15:0] m_forward_speed,
    output logic signed [15:0] m_sideways_speed,
    output logic               m_docked,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Filter numerator width, and width of the offset-corrected left distance
    localparam int FW = SAMPLE_BITS + 4;
    localparam int OW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int LW = OW + 1;
    localparam int PW = FW + 29;

    // floor((raw + 9 * prev) / 10) by reciprocal multiplication
    function automatic logic [SAMPLE_BITS-1:0] lp_filter(
        input logic [SAMPLE_BITS-1:0] raw,
        input logic [SAMPLE_BITS-1:0] prev
    );
        logic [FW-1:0] num;
        logic [PW-1:0] prod;
        num  = FW'(raw) + {1'b0, prev, 3'b000} + FW'(prev);
        prod = PW'(num) * PW'(DIV10_RECIP);
        return prod[DIV10_SHIFT +: SAMPLE_BITS];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] target_distance_reg;
    logic [15:0] side_threshold_reg;
    logic [15:0] left_offset_reg;
    logic [14:0] fast_y_speed_reg;
    logic [14:0] slow_y_speed_reg;

    assign cfg_ready = 1'b1;

    // A write to an index outside the register list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_distance_reg <= TARGET_DISTANCE_RST;
            side_threshold_reg  <= SIDE_THRESHOLD_RST;
            left_offset_reg     <= LEFT_OFFSET_RST;
            fast_y_speed_reg    <= FAST_Y_SPEED_RST;
            slow_y_speed_reg    <= SLOW_Y_SPEED_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TARGET_DISTANCE: target_distance_reg <= cfg_data;
                CFG_SIDE_THRESHOLD:  side_threshold_reg  <= cfg_data;
                CFG_LEFT_OFFSET:     left_offset_reg     <= cfg_data;
                CFG_FAST_Y_SPEED:    fast_y_speed_reg    <= cfg_data[14:0];
                CFG_SLOW_Y_SPEED:    slow_y_speed_reg    <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic adv1, adv2, adv3, adv4;

    // A stage may load when it is empty or its contents move on.
    assign rdy4 = !v4_reg || m_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign adv1 = s_valid && rdy1;
    assign adv2 = v1_reg && rdy2;
    assign adv3 = v2_reg && rdy3;
    assign adv4 = v3_reg && rdy4;

    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register, selected side sensors kept only
    // ------------------------------------------------------------------
    logic                   is_left1_reg;
    logic [SAMPLE_BITS-1:0] raw_left1_reg;
    logic [SAMPLE_BITS-1:0] raw_right1_reg;
    logic [15:0]            slow_sense1_reg;
    logic [15:0]            stop_sense1_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            is_left1_reg    <= s_is_left;
            raw_left1_reg   <= SAMPLE_BITS'(s_behind_left_raw);
            raw_right1_reg  <= SAMPLE_BITS'(s_behind_right_raw);
            slow_sense1_reg <= s_is_left ? s_side_left_slow : s_side_right_slow;
            stop_sense1_reg <= s_is_left ? s_side_left_stop : s_side_right_stop;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: filter update and sideways speed magnitude
    // ------------------------------------------------------------------
    // The filter state doubles as this stage's payload: both change only
    // when a sample moves in from stage 1.
    logic [SAMPLE_BITS-1:0] filtered_left_reg;
    logic [SAMPLE_BITS-1:0] filtered_right_reg;
    logic [SAMPLE_BITS-1:0] filtered_left_next;
    logic [SAMPLE_BITS-1:0] filtered_right_next;
    logic                   is_left2_reg;
    logic [14:0]            y_mag2_reg;
    logic [14:0]            y_mag_next;
    logic [14:0]            fast_sat;
    logic [14:0]            slow_sat;

    assign filtered_left_next  = lp_filter(raw_left1_reg, filtered_left_reg);
    assign filtered_right_next = lp_filter(raw_right1_reg, filtered_right_reg);

    // Speeds above unity are saturated; the stop stage wins over slow.
    always_comb begin
        fast_sat = (fast_y_speed_reg > ONE_Q14) ? ONE_Q14 : fast_y_speed_reg;
        slow_sat = (slow_y_speed_reg > ONE_Q14) ? ONE_Q14 : slow_y_speed_reg;
        y_mag_next = fast_sat;
        if (slow_sense1_reg > side_threshold_reg) begin
            y_mag_next = slow_sat;
        end
        if (stop_sense1_reg > side_threshold_reg) begin
            y_mag_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filtered_left_reg  <= '0;
            filtered_right_reg <= '0;
        end else if (adv2) begin
            filtered_left_reg  <= filtered_left_next;
            filtered_right_reg <= filtered_right_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            is_left2_reg <= is_left1_reg;
            y_mag2_reg   <= y_mag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: differences, magnitudes and rounding numerators
    // ------------------------------------------------------------------
    logic [LW-1:0]     left_dist;
    logic [LW-1:0]     right_dist;
    logic signed [LW:0] diff;
    logic [LW:0]       diff_neg;
    logic [LW-1:0]     diff_mag;
    logic [13:0]       diff_cap;
    logic [15:0]       diff_cap5;
    logic [LW:0]       dist_sum;
    logic [LW-1:0]     dist_mean;
    logic signed [LW:0] err;
    logic [LW:0]       err_neg;
    logic [LW-1:0]     err_mag;
    logic [10:0]       err_cap;
    logic [15:0]       side_mag16;

    logic [31:0]        ang_num3_reg;
    logic               ang_neg3_reg;
    logic [20:0]        fwd_num3_reg;
    logic               fwd_neg3_reg;
    logic signed [15:0] side3_reg;
    logic               docked3_reg;

    always_comb begin
        left_dist  = LW'(filtered_left_reg) + LW'(left_offset_reg);
        right_dist = LW'(filtered_right_reg);

        // Yaw: |L - R| capped where the result clamps anyway
        diff     = $signed({1'b0, left_dist}) - $signed({1'b0, right_dist});
        diff_neg = -diff;
        diff_mag = diff[LW] ? diff_neg[LW-1:0] : diff[LW-1:0];
        diff_cap = (diff_mag > LW'(ANG_MAG_CAP)) ? ANG_MAG_CAP : diff_mag[13:0];
        diff_cap5 = {diff_cap, 2'b00} + {2'b00, diff_cap};

        // Forward: target minus the floored mean distance
        dist_sum  = {1'b0, left_dist} + {1'b0, right_dist};
        dist_mean = dist_sum[LW:1];
        err       = $signed({1'b0, LW'(target_distance_reg)}) - $signed({1'b0, dist_mean});
        err_neg   = -err;
        err_mag   = err[LW] ? err_neg[LW-1:0] : err[LW-1:0];
        err_cap   = (err_mag > LW'(FWD_MAG_CAP)) ? FWD_MAG_CAP : err_mag[10:0];

        side_mag16 = {1'b0, y_mag2_reg};
    end

    // Yaw numerator is 327680 * mag + 65535, over 131070.
    // Forward numerator is (2048 * mag + 125) / 2, over 125.
    always_ff @(posedge aclk) begin
        if (adv3) begin
            ang_num3_reg <= {diff_cap5, 16'hFFFF};
            ang_neg3_reg <= diff[LW];
            fwd_num3_reg <= {err_cap, 10'd62};
            fwd_neg3_reg <= err[LW];
            side3_reg    <= is_left2_reg ? side_mag16 : (16'd0 - side_mag16);
            docked3_reg  <= (y_mag2_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: constant divisions, clamps and the output register
    // ------------------------------------------------------------------
    logic [65:0] ang_prod;
    logic [16:0] ang_quot;
    logic [16:0] ang_clip;
    logic [42:0] fwd_prod;
    logic [14:0] fwd_quot;
    logic [14:0] fwd_clip;
    logic [15:0] ang_next;
    logic [15:0] fwd_next;

    always_comb begin
        // Multiply by 2^32 + 2^16 + 2, then shift by 49: exact over 131070
        ang_prod = {2'b00, ang_num3_reg, 32'd0}
                 + {18'd0, ang_num3_reg, 16'd0}
                 + {33'd0, ang_num3_reg, 1'b0};
        ang_quot = ang_prod[65:49];
        ang_clip = (ang_quot > ANG_LIMIT) ? ANG_LIMIT : ang_quot;
        ang_next = ang_neg3_reg ? (16'd0 - ang_clip[15:0]) : ang_clip[15:0];

        fwd_prod = {22'd0, fwd_num3_reg} * {21'd0, DIV125_RECIP};
        fwd_quot = fwd_prod[DIV125_SHIFT +: 15];
        fwd_clip = (fwd_quot > ONE_Q14) ? ONE_Q14 : fwd_quot;
        fwd_next = fwd_neg3_reg ? (16'd0 - {1'b0, fwd_clip}) : {1'b0, fwd_clip};
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            m_angular_rate   <= ang_next;
            m_forward_speed  <= fwd_next;
            m_sideways_speed <= side3_reg;
            m_docked         <= docked3_reg;
        end
    end

`ifndef ASSERT_OFF
    // The done flag agrees with the sideways speed it describes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_docked == (m_sideways_speed == 16'sd0)))
    else $error("docked flag disagrees with sideways speed");

    // The yaw rate never leaves its clamp range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angular_rate <= 16'sd20808 && m_angular_rate >= -16'sd20808))
    else $error("angular rate outside its limit");

    // The forward speed never leaves unity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_forward_speed <= 16'sd16384 && m_forward_speed >= -16'sd16384))
    else $error("forward speed outside its limit");

    // The filters move only when a sample leaves the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv2 |=> ($stable(filtered_left_reg) && $stable(filtered_right_reg)))
    else $error("filter state changed without a sample");

    // With the output register empty the whole pipeline can take data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
    else $error("input stalled while output register empty");
`endif

endmodule
